FILE: hdl/lpd_pkg.sv
// Shared constants and types for the length-prefix deframer.
`default_nettype none
package lpd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int HDR_CNT_W    = 3;
  localparam int LEN_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  // header_count wraps modulo 8, so the completion value is taken the same way
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES % 8);

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(65536);

  // register index (word address bit paddr[2])
  localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  typedef struct packed {
    logic              has_result;
    status_t           status;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/lpd_core.sv
// Deframer state and per-byte decode: header collection, payload count, error.
`default_nettype none
module lpd_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [lpd_pkg::BYTE_W-1:0] stream_byte,
  input  wire logic [lpd_pkg::LEN_W-1:0]  max_frame_length,
  output lpd_pkg::result_t                res
);
  import lpd_pkg::*;

  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0]     length_shift, length_shift_next;
  logic [LEN_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic                 in_payload, in_payload_next;
  logic                 error_latched, error_latched_next;

  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     rem_dec;
  logic [HDR_CNT_W-1:0] cnt_inc;

  always_comb begin
    len     = {length_shift[LEN_W-BYTE_W-1:0], stream_byte};
    rem_dec = bytes_remaining - LEN_W'(1);
    cnt_inc = header_count + HDR_CNT_W'(1);

    header_count_next    = header_count;
    length_shift_next    = length_shift;
    bytes_remaining_next = bytes_remaining;
    in_payload_next      = in_payload;
    error_latched_next   = error_latched;

    res.has_result   = 1'b0;
    res.status       = ST_PAYLOAD;
    res.payload_byte = '0;
    res.frame_end    = 1'b0;

    if (error_latched) begin
      res.has_result = 1'b1;
      res.status     = ST_ERROR;
    end else if (in_payload) begin
      bytes_remaining_next = rem_dec;
      res.has_result       = 1'b1;
      res.payload_byte     = stream_byte;
      if (rem_dec == '0) begin
        in_payload_next = 1'b0;
        res.frame_end   = 1'b1;
      end
    end else if (cnt_inc != HDR_LAST) begin
      length_shift_next = len;
      header_count_next = cnt_inc;
    end else begin
      // header complete
      header_count_next = '0;
      length_shift_next = '0;
      if (len > max_frame_length) begin
        error_latched_next = 1'b1;
        res.has_result     = 1'b1;
        res.status         = ST_ERROR;
      end else if (len == '0) begin
        res.has_result = 1'b1;
        res.status     = ST_EMPTY;
        res.frame_end  = 1'b1;
      end else begin
        bytes_remaining_next = len;
        in_payload_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      length_shift    <= '0;
      bytes_remaining <= '0;
      in_payload      <= 1'b0;
      error_latched   <= 1'b0;
    end else if (step) begin
      header_count    <= header_count_next;
      length_shift    <= length_shift_next;
      bytes_remaining <= bytes_remaining_next;
      in_payload      <= in_payload_next;
      error_latched   <= error_latched_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/length_prefix_deframer.sv
// Top level: input register, deframer core, result register and APB register.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    stream_byte
//   output    out        out_valid/out_ready  status, payload_byte, frame_end
//   config    in/out     APB psel/penable     paddr, pwdata, prdata
//
// One byte per cycle sustained while results are taken; each byte waits in
// the input register and is decoded into the result register as it leaves.
// Bytes that give no result, such as most header bytes, move on even while
// the result register is full; other bytes wait until the held result is taken.
// Synchronous reset clears all control state; max_frame_length resets to 65536.
`default_nettype none
module length_prefix_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lpd_pkg::BYTE_W-1:0]     stream_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          status,
  output logic [lpd_pkg::BYTE_W-1:0]          payload_byte,
  output logic                                frame_end,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import lpd_pkg::*;

  logic [LEN_W-1:0]  max_frame_length;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;
  logic              step;
  result_t           res;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME_LENGTH)) begin
      max_frame_length <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_FRAME_LENGTH) begin
      prdata = max_frame_length;
    end
  end

  // input register advances when the held byte can be consumed
  assign step     = byte_valid && (!out_valid || out_ready || !res.has_result);
  assign in_ready = !byte_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= stream_byte;
    end
  end

  lpd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .stream_byte      (byte_q),
    .max_frame_length (max_frame_length),
    .res              (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.has_result) begin
      status       <= res.status;
      payload_byte <= res.payload_byte;
      frame_end    <= res.frame_end;
    end
  end

endmodule
`default_nettype wire
